### rtl/core/tswd_pkg.sv
// ----------------------------------------------------------------------------
// Task stall watchdog package
// Shared widths and reset constants of the task stall watchdog.
// ----------------------------------------------------------------------------
package tswd_pkg;

    localparam int TS_W = 32;
    localparam logic [TS_W-1:0] STALL_LIMIT_RESET = TS_W'(10 * 60 * 1000);

endpackage

### rtl/core/task_stall_watchdog_monitor_top.sv
// ----------------------------------------------------------------------------
// Task stall watchdog monitor
// Multi-channel run-time monitor with a tick counter advanced by tick
// transactions and a stall check that scans the channels in order.
// ----------------------------------------------------------------------------
// A tick or a start transaction is done in the idle state; an end transaction
// also passes through ST_END, since the end reads the channel's stamp and run
// record from the store before it writes the new record back. A check emits one
// report per channel up to and including the first stalled one, and holds while
// the output is back-pressured; the store has one read port, read once per
// channel. A stalled channel ends the scan with restart set and returns the
// counter and all channel state to zero; the stall limit keeps its value.
module task_stall_watchdog_monitor_top #(
    parameter int CHANNELS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // op[1:0], channel[4:2], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,  // report_channel[2:0], active[3], run_time[35:4],
                                  // run_count[67:36], stalled[68], restart[69], zero pad
    output logic        m_tlast
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int XW = ((AW > 3) ? AW : 3) + 1;
    localparam int TW = tswd_pkg::TS_W;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_END   = 2'd2,
        OP_CHECK = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_END  = 3'b010,
        ST_SCAN = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    logic [TW-1:0]   limit_reg;
    logic [TW-1:0]   now_reg, now_next;
    logic [XW-1:0]   idx_reg, idx_next;
    logic [AW-1:0]   end_addr_reg, end_addr_next;
    logic            m_valid_reg, m_valid_next;
    logic [71:0]     m_data_reg, m_data_next;
    logic            m_last_reg, m_last_next;

    op_t             in_op;
    logic [XW-1:0]   in_chan;
    logic            in_range;
    logic            accept;
    logic            out_free;

    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;
    logic            stamp_we;
    logic            run_we;
    logic            clear;
    logic [TW-1:0]   rd_stamp;
    logic [TW-1:0]   rd_time;
    logic [TW-1:0]   rd_count;

    logic            rep_active;
    logic [TW-1:0]   elapsed;
    logic            rep_stall;
    logic            rep_final;

    assign in_op    = op_t'(s_tdata[1:0]);
    assign in_chan  = XW'(s_tdata[4:2]);
    assign in_range = in_chan < XW'(CHANNELS);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign rep_active = (rd_time != '0) || (rd_count != '0);
    assign elapsed    = now_reg - rd_stamp;
    assign rep_stall  = rep_active && (elapsed > limit_reg);
    assign rep_final  = rep_stall || (idx_reg == XW'(CHANNELS - 1));

    always_comb begin
        state_next    = state_reg;
        now_next      = now_reg;
        idx_next      = idx_reg;
        end_addr_next = end_addr_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;
        rd_en         = 1'b0;
        rd_addr       = in_chan[AW-1:0];
        wr_addr       = in_chan[AW-1:0];
        stamp_we      = 1'b0;
        run_we        = 1'b0;
        clear         = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (in_op)
                        OP_TICK: begin
                            now_next = now_reg + 1'b1;
                        end
                        OP_START: begin
                            stamp_we = in_range;
                        end
                        OP_END: begin
                            if (in_range) begin
                                rd_en         = 1'b1;
                                end_addr_next = in_chan[AW-1:0];
                                state_next    = ST_END;
                            end
                        end
                        OP_CHECK: begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            idx_next   = '0;
                            state_next = ST_SCAN;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_END: begin
                wr_addr    = end_addr_reg;
                run_we     = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_last_next  = rep_final;
                    m_data_next  = {2'b00, rep_stall, rep_stall, rd_count, rd_time,
                                    rep_active, idx_reg[2:0]};
                    if (rep_stall) begin
                        clear      = 1'b1;
                        now_next   = '0;
                        state_next = ST_IDLE;
                    end else if (rep_final) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                        rd_en    = 1'b1;
                        rd_addr  = idx_next[AW-1:0];
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            now_reg     <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
            limit_reg   <= tswd_pkg::STALL_LIMIT_RESET;
        end else begin
            state_reg   <= state_next;
            now_reg     <= now_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        end_addr_reg <= end_addr_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
    end

    tswd_chan_store #(
        .CHANNELS (CHANNELS),
        .AW       (AW)
    ) u_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .wr_addr     (wr_addr),
        .stamp_we    (stamp_we),
        .stamp_wdata (now_reg),
        .run_we      (run_we),
        .time_wdata  (now_reg - rd_stamp),
        .count_wdata (rd_count + 1'b1),
        .clear       (clear),
        .rd_stamp    (rd_stamp),
        .rd_time     (rd_time),
        .rd_count    (rd_count)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    a_restart_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[69] |-> m_tlast && m_tdata[68] && m_tdata[3])
        else $error("restart report must be a stalled, active, final report");

    a_stall_clears_time: assert property (@(posedge aclk) disable iff (!aresetn)
        clear |=> now_reg == '0 && state_reg == ST_IDLE)
        else $error("stall did not return the tick counter to zero");

    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> !stamp_we && !run_we)
        else $error("channel store written during a check scan");

    a_end_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        run_we |-> $past(rd_en) && $past(accept))
        else $error("run record written without a preceding store read");

endmodule

### rtl/core/tswd_chan_store.sv
// ----------------------------------------------------------------------------
// Task stall watchdog channel store
// Per-channel start stamps and run records in two synchronous memories with
// registered read data. Valid bits make unwritten entries read as zero.
// ----------------------------------------------------------------------------
module tswd_chan_store #(
    parameter int CHANNELS = 8,
    parameter int AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     rd_en,
    input  logic [AW-1:0]            rd_addr,
    input  logic [AW-1:0]            wr_addr,
    input  logic                     stamp_we,
    input  logic [tswd_pkg::TS_W-1:0] stamp_wdata,
    input  logic                     run_we,
    input  logic [tswd_pkg::TS_W-1:0] time_wdata,
    input  logic [tswd_pkg::TS_W-1:0] count_wdata,
    input  logic                     clear,
    output logic [tswd_pkg::TS_W-1:0] rd_stamp,
    output logic [tswd_pkg::TS_W-1:0] rd_time,
    output logic [tswd_pkg::TS_W-1:0] rd_count
);

    logic [tswd_pkg::TS_W-1:0]   stamp_mem [CHANNELS];
    logic [2*tswd_pkg::TS_W-1:0] run_mem   [CHANNELS];

    logic [CHANNELS-1:0]         vld_stamp_reg;
    logic [CHANNELS-1:0]         vld_run_reg;
    logic [tswd_pkg::TS_W-1:0]   rd_stamp_reg;
    logic [2*tswd_pkg::TS_W-1:0] rd_run_reg;
    logic                        rd_stamp_vld_reg;
    logic                        rd_run_vld_reg;

    always_ff @(posedge aclk) begin
        if (stamp_we) begin
            stamp_mem[wr_addr] <= stamp_wdata;
        end
        if (rd_en) begin
            rd_stamp_reg <= stamp_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (run_we) begin
            run_mem[wr_addr] <= {count_wdata, time_wdata};
        end
        if (rd_en) begin
            rd_run_reg <= run_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            vld_stamp_reg    <= '0;
            vld_run_reg      <= '0;
            rd_stamp_vld_reg <= 1'b0;
            rd_run_vld_reg   <= 1'b0;
        end else begin
            if (stamp_we) begin
                vld_stamp_reg[wr_addr] <= 1'b1;
            end
            if (run_we) begin
                vld_run_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_stamp_vld_reg <= vld_stamp_reg[rd_addr];
                rd_run_vld_reg   <= vld_run_reg[rd_addr];
            end
        end
    end

    assign rd_stamp = rd_stamp_vld_reg ? rd_stamp_reg : '0;
    assign rd_time  = rd_run_vld_reg ? rd_run_reg[tswd_pkg::TS_W-1:0] : '0;
    assign rd_count = rd_run_vld_reg ? rd_run_reg[2*tswd_pkg::TS_W-1:tswd_pkg::TS_W] : '0;

endmodule
